// File: rtl/scv_pkg.sv
package scv_pkg;

   localparam int IMAGE_SIZE_DEF = 8;
   localparam int MAX_KERNEL_DEF = 8;

   localparam int IDX_W    = 3;
   localparam int KROWS    = 8;
   localparam int ACC_N    = 8;
   localparam int IMG_AW   = 2 * IDX_W;
   localparam int IMG_N    = 1 << IMG_AW;
   localparam int REG_W    = 4;
   localparam int REQ_TDW  = 24;
   localparam int RSP_TDW  = 48;

   localparam logic [0:0] REG_KERNEL_SIZE = 1'b0;
   localparam logic [0:0] REG_STRIDE      = 1'b1;

   localparam logic FUNC_KERNEL = 1'b0;
   localparam logic FUNC_IMAGE  = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef logic signed [15:0] pix_type;
   typedef logic signed [31:0] prod_type;
   typedef logic signed [37:0] sum_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      pix_type          value;
   } kwr_type;

   typedef struct packed {
      logic             vld;
      logic             cap;
      logic             zfirst;
      logic [IDX_W-1:0] z;
      logic [IDX_W-1:0] j;
   } tag_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_STREAM = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_EMIT   = 6'b010000,
      ST_FAIL   = 6'b100000
   } state_type;

endpackage

// File: rtl/scv_cell.sv
module scv_cell #(
   parameter int COL_IDX = 0
) (
   input  logic              clock,
   input  scv_pkg::kwr_type  kwr,
   input  scv_pkg::pix_type  pixel,
   input  logic [2:0]        zsel,
   input  scv_pkg::sum_type  psum_in,
   output scv_pkg::sum_type  psum_out
);
   import scv_pkg::*;

   pix_type  coef_mem [KROWS];
   prod_type prod_ff;
   sum_type  psum_ff;

   // hold one kernel column; multiply, then add onto the neighbor's partial sum
   always_ff @(posedge clock) begin
      if (kwr.en && kwr.col == IDX_W'(COL_IDX)) begin
         coef_mem[kwr.row] <= kwr.value;
      end
      prod_ff <= coef_mem[zsel] * pixel;
      psum_ff <= psum_in + sum_type'(prod_ff);
   end

   assign psum_out = psum_ff;

endmodule

// File: rtl/scv_chain.sv
module scv_chain #(
   parameter int MAX_KERNEL = scv_pkg::MAX_KERNEL_DEF
) (
   input  logic                      clock,
   input  scv_pkg::kwr_type          kwr,
   input  scv_pkg::pix_type          pixel,
   input  logic [2:0]                zsel,
   input  logic [scv_pkg::REG_W-1:0] ksel,
   output scv_pkg::sum_type          tap
);
   import scv_pkg::*;

   sum_type link [MAX_KERNEL+1];

   assign link[0] = '0;

   for (genvar n = 0; n < MAX_KERNEL; n++) begin : g_cell
      scv_cell #(.COL_IDX(n)) u_cell (
         .clock    (clock),
         .kwr      (kwr),
         .pixel    (pixel),
         .zsel     (zsel),
         .psum_in  (link[n]),
         .psum_out (link[n+1])
      );
   end

   // pick the cell at the kernel width: it holds the full window row sum
   always_comb begin
      tap = '0;
      for (int n = 0; n < MAX_KERNEL; n++) begin
         if (ksel == REG_W'(n + 1)) begin
            tap = link[n+1];
         end
      end
   end

endmodule

// File: rtl/strided_valid_conv2d.sv
// Strided valid 2D convolution. Each req transaction writes a kernel
// coefficient (tuser 0) or an image pixel (tuser 1); loads are taken one per
// cycle while idle. Writing the bottom-right pixel starts a run and drops
// req_tready until the run has handed its last result to the output register.
// A run first checks the sizes, one stride subtraction a cycle; on failure it
// gives one error result (tuser 1, tlast 1, data 0). Otherwise, for each of
// the m output rows, it streams k image rows of IMAGE_SIZE pixels, one pixel a
// cycle from the single read port of the image memory, through a chain of
// multiply-accumulate cells (one per kernel column), lets the chain drain until
// no tagged pixel is left in its tag registers, and then emits m results, one a
// cycle while the output is not stalled. The image memory port limits the
// speed of a run. Results leave through a registered output stage, so loads of
// the next image may go on while the final result waits.
module strided_valid_conv2d #(
   parameter int IMAGE_SIZE = scv_pkg::IMAGE_SIZE_DEF,
   parameter int MAX_KERNEL = scv_pkg::MAX_KERNEL_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [scv_pkg::REQ_TDW-1:0] req_tdata,  // row[2:0], col[5:3], value[21:6]
   input  logic                        req_tuser,  // func
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [scv_pkg::RSP_TDW-1:0] rsp_tdata,  // out_row[2:0], out_col[5:3], sum[43:6]
   output logic                        rsp_tuser,  // status
   output logic                        rsp_tlast,
   input  logic                        csr_wen,
   input  logic [0:0]                  csr_addr,
   input  logic [scv_pkg::REG_W-1:0]   csr_wdata
);
   import scv_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(IMAGE_SIZE - 1);

   state_type        state_ff, state_in;
   logic [REG_W-1:0] kernel_size_ff, stride_ff;
   logic [REG_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0] mlast_ff, mlast_in;
   logic             bad_ff, bad_in;
   logic [IDX_W-1:0] i_ff, i_in, ej_ff, ej_in;
   logic [IDX_W-1:0] z_ff, z_in, c_ff, c_in, j_ff, j_in;
   logic [REG_W-1:0] nextcap_ff, nextcap_in, rowbase_ff, rowbase_in;
   tag_type          tag0, tag1_ff, tag2_ff, tag3_ff;
   pix_type          img_mem [IMG_N];
   pix_type          img_rd_ff;
   sum_type          acc_ff [ACC_N];
   sum_type          tap;
   logic [IDX_W-1:0] acc_idx;
   logic [REG_W-1:0] img_row;
   logic [IMG_AW-1:0] rd_addr;
   kwr_type          kwr;

   logic             rsp_valid_ff, rsp_load;
   logic             rsp_status_ff, rsp_status_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [IDX_W-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   sum_type          rsp_sum_ff, rsp_sum_in;

   logic             req_acc, out_free, is_image, img_wr, last_pix;
   logic [IDX_W-1:0] req_row, req_col;
   pix_type          req_value;

   // unpack the request
   assign req_row   = req_tdata[2:0];
   assign req_col   = req_tdata[5:3];
   assign req_value = req_tdata[21:6];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc   = req_tvalid && req_tready;
   assign is_image  = (req_tuser == FUNC_IMAGE);
   assign img_wr    = req_acc && is_image && ({1'b0, req_row} < REG_W'(IMAGE_SIZE))
                      && ({1'b0, req_col} < REG_W'(IMAGE_SIZE));
   assign last_pix  = img_wr && req_row == LAST_IDX && req_col == LAST_IDX;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // kernel writes go straight to the cell that owns the column
   always_comb begin
      kwr.en    = req_acc && !is_image && ({1'b0, req_row} < REG_W'(MAX_KERNEL));
      kwr.row   = req_row;
      kwr.col   = req_col;
      kwr.value = req_value;
   end

   // issue one pixel per cycle while streaming; mark window ends for capture
   assign img_row = rowbase_ff + {1'b0, z_ff};
   assign rd_addr = {img_row[IDX_W-1:0], c_ff};
   always_comb begin
      tag0.vld    = (state_ff == ST_STREAM);
      tag0.cap    = ({1'b0, c_ff} == nextcap_ff);
      tag0.zfirst = (z_ff == '0);
      tag0.z      = z_ff;
      tag0.j      = j_ff;
   end

   always_ff @(posedge clock) begin
      if (img_wr) begin
         img_mem[{req_row, req_col}] <= req_value;
      end
      img_rd_ff <= img_mem[rd_addr];
   end

   scv_chain #(.MAX_KERNEL(MAX_KERNEL)) u_chain (
      .clock (clock),
      .kwr   (kwr),
      .pixel (img_rd_ff),
      .zsel  (tag1_ff.z),
      .ksel  (kernel_size_ff),
      .tap   (tap)
   );

   // accumulate window row sums over the kernel rows, one slot per output column
   assign acc_idx = (state_ff == ST_EMIT) ? ej_ff : tag3_ff.j;
   always_ff @(posedge clock) begin
      if (tag3_ff.vld && tag3_ff.cap) begin
         acc_ff[acc_idx] <= tag3_ff.zfirst ? tap : acc_ff[acc_idx] + tap;
      end
   end

   // run sequencer
   always_comb begin
      state_in      = state_ff;
      rem_in        = rem_ff;
      mlast_in      = mlast_ff;
      bad_in        = bad_ff;
      i_in          = i_ff;
      ej_in         = ej_ff;
      z_in          = z_ff;
      c_in          = c_ff;
      j_in          = j_ff;
      nextcap_in    = nextcap_ff;
      rowbase_in    = rowbase_ff;
      rsp_load      = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_row_in    = '0;
      rsp_col_in    = '0;
      rsp_sum_in    = '0;
      rsp_last_in   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (last_pix) begin
               bad_in   = kernel_size_ff == '0 || stride_ff == '0
                          || kernel_size_ff > REG_W'(MAX_KERNEL)
                          || kernel_size_ff > REG_W'(IMAGE_SIZE);
               rem_in   = REG_W'(IMAGE_SIZE) - kernel_size_ff;
               mlast_in = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (bad_ff) begin
               state_in = ST_FAIL;
            end else if (rem_ff == '0) begin
               i_in       = '0;
               rowbase_in = '0;
               z_in       = '0;
               c_in       = '0;
               j_in       = '0;
               nextcap_in = kernel_size_ff - 1'b1;
               state_in   = ST_STREAM;
            end else if (rem_ff >= stride_ff) begin
               rem_in   = rem_ff - stride_ff;
               mlast_in = mlast_ff + 1'b1;
            end else begin
               state_in = ST_FAIL;
            end
         end
         ST_STREAM: begin
            if (c_ff == LAST_IDX) begin
               c_in       = '0;
               j_in       = '0;
               nextcap_in = kernel_size_ff - 1'b1;
               if ({1'b0, z_ff} == kernel_size_ff - 1'b1) begin
                  z_in     = '0;
                  state_in = ST_DRAIN;
               end else begin
                  z_in = z_ff + 1'b1;
               end
            end else begin
               c_in = c_ff + 1'b1;
               if (tag0.cap) begin
                  nextcap_in = nextcap_ff + stride_ff;
                  j_in       = j_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (!tag1_ff.vld && !tag2_ff.vld && !tag3_ff.vld) begin
               ej_in    = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_row_in  = i_ff;
               rsp_col_in  = ej_ff;
               rsp_sum_in  = acc_ff[acc_idx];
               rsp_last_in = (i_ff == mlast_ff) && (ej_ff == mlast_ff);
               if (ej_ff == mlast_ff) begin
                  ej_in = '0;
                  if (i_ff == mlast_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     i_in       = i_ff + 1'b1;
                     rowbase_in = rowbase_ff + stride_ff;
                     state_in   = ST_STREAM;
                  end
               end else begin
                  ej_in = ej_ff + 1'b1;
               end
            end
         end
         ST_FAIL: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = STATUS_ERR;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         kernel_size_ff <= REG_W'(3);
         stride_ff      <= REG_W'(1);
         rsp_valid_ff   <= 1'b0;
         tag1_ff        <= '0;
         tag2_ff        <= '0;
         tag3_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wen && csr_addr == REG_KERNEL_SIZE) begin
            kernel_size_ff <= csr_wdata;
         end
         if (csr_wen && csr_addr == REG_STRIDE) begin
            stride_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         tag1_ff <= tag0;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   // counters and result payload; each is set on entry to the state using it
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      mlast_ff   <= mlast_in;
      bad_ff     <= bad_in;
      i_ff       <= i_in;
      ej_ff      <= ej_in;
      z_ff       <= z_in;
      c_ff       <= c_in;
      j_ff       <= j_in;
      nextcap_ff <= nextcap_in;
      rowbase_ff <= rowbase_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_row_ff    <= rsp_row_in;
         rsp_col_ff    <= rsp_col_in;
         rsp_sum_ff    <= rsp_sum_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000, rsp_sum_ff, rsp_col_ff, rsp_row_ff};

endmodule

// File: rtl/scv_checker.sv
module scv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // an error result is a run of its own
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("error result without last");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 48'd0)
      else $error("error result carries data");

   // results other than the final one only come mid-run, with input closed
   a_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input open during a run");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind strided_valid_conv2d scv_checker u_scv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: dv/conv_checker.sv
module conv_checker
   import scv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [REQ_TDW-1:0]   req_tdata,
   input  logic                 req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [RSP_TDW-1:0]   rsp_tdata,
   input  logic                 rsp_tuser,
   input  logic                 rsp_tlast,
   input  logic                 csr_wen,
   input  logic [0:0]           csr_addr,
   input  logic [REG_W-1:0]     csr_wdata,
   output int                   fail_count,
   output int                   pending
);

   typedef struct packed {
      logic        status;
      logic [2:0]  row;
      logic [2:0]  col;
      logic [37:0] sum;
      logic        last;
   } conv_elem_type;

   conv_elem_type expected_elems[$];
   pix_type     image_mem[64];
   pix_type     kernel_mem[64];
   logic [3:0]  ksize;
   logic [3:0]  kstep;

   initial begin
      fail_count = 0;
      pending    = 0;
      ksize      = 3;
      kstep      = 1;
   end

   task automatic queue_conv_run();
      int            k;
      int            s;
      int            m;
      longint        acc;
      conv_elem_type e;
      k = ksize;
      s = kstep;
      if (k == 0 || k > 8 || s == 0 || k > 8 || ((8 - k) % s) != 0) begin
         e = '{status: STATUS_ERR, row: 0, col: 0, sum: '0, last: 1'b1};
         expected_elems.push_back(e);
      end else begin
         m = (8 - k) / s + 1;
         for (int i = 0; i < m; i++) begin
            for (int j = 0; j < m; j++) begin
               acc = 0;
               for (int z = 0; z < k; z++)
                  for (int x = 0; x < k; x++)
                     acc += longint'(image_mem[(i*s+z)*8 + j*s+x])
                          * longint'(kernel_mem[z*8 + x]);
               e.status = STATUS_OK;
               e.row    = i[2:0];
               e.col    = j[2:0];
               e.sum    = acc[37:0];
               e.last   = (i == m-1 && j == m-1);
               expected_elems.push_back(e);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      conv_elem_type got;
      conv_elem_type want;
      if (!reset) begin
         if (csr_wen) begin
            if (csr_addr == REG_KERNEL_SIZE) ksize = csr_wdata;
            else kstep = csr_wdata;
         end
         // store the written entry; bottom-right pixel kicks off a run
         if (req_tvalid && req_tready) begin
            if (req_tuser == FUNC_KERNEL) begin
               kernel_mem[req_tdata[2:0]*8 + req_tdata[5:3]] = req_tdata[21:6];
            end else begin
               image_mem[req_tdata[2:0]*8 + req_tdata[5:3]] = req_tdata[21:6];
               if (req_tdata[2:0] == 3'd7 && req_tdata[5:3] == 3'd7) queue_conv_run();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{status: rsp_tuser, row: rsp_tdata[2:0], col: rsp_tdata[5:3],
                    sum: rsp_tdata[43:6], last: rsp_tlast};
            if (expected_elems.size() == 0) begin
               $display("%0t unexpected result st=%0d r=%0d c=%0d sum=%0d last=%0d",
                        $time, got.status, got.row, got.col, $signed(got.sum), got.last);
               fail_count++;
            end else begin
               want = expected_elems.pop_front();
               if (got !== want) begin
                  $display("%0t mismatch exp st=%0d r=%0d c=%0d sum=%0d last=%0d %s",
                           $time, want.status, want.row, want.col, $signed(want.sum),
                           want.last, "");
                  $display("%0t          act st=%0d r=%0d c=%0d sum=%0d last=%0d",
                           $time, got.status, got.row, got.col, $signed(got.sum),
                           got.last);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_elems.size();
   end

endmodule

// File: dv/strided_valid_conv2d_tb.sv
module strided_valid_conv2d_tb;
   import scv_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_TDW-1:0] req_tdata = '0;
   logic               req_tuser = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_TDW-1:0] rsp_tdata;
   logic               rsp_tuser;
   logic               rsp_tlast;
   logic               csr_wen = 1'b0;
   logic [0:0]         csr_addr = REG_KERNEL_SIZE;
   logic [REG_W-1:0]   csr_wdata = '0;

   int fail_count;
   int pending;

   // idle percentages for sender and receiver, changed per phase
   int snd_idle = 24;
   int rcv_idle = 69;

   // track which entries hold data, so no run reads an unwritten one
   bit img_written[64];
   bit ker_written[64];
   int cur_k = 3;
   int cur_s = 1;

   always #10 clock = ~clock;

   strided_valid_conv2d DUT (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_wen, .csr_addr, .csr_wdata
   );

   conv_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_wen, .csr_addr, .csr_wdata,
      .fail_count, .pending
   );

   // receiver stalls at random
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= rcv_idle);
   end

   function automatic logic [15:0] pick_value();
      case ($urandom_range(9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // present one transaction; hold until accepted, leave tvalid high after
   task automatic send_write(logic func, int row, int col, logic [15:0] value);
      while ($urandom_range(99) < snd_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = {2'b00, value, col[2:0], row[2:0]};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (func == FUNC_KERNEL) ker_written[row*8+col] = 1'b1;
      else img_written[row*8+col] = 1'b1;
   endtask

   // drain all outstanding results, then let the block settle
   task automatic wait_quiet();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // update both registers; only called while the block is quiet
   task automatic set_shape(int k, int s);
      csr_wen   = 1'b1;
      csr_addr  = REG_KERNEL_SIZE;
      csr_wdata = k[3:0];
      @(negedge clock);
      csr_addr  = REG_STRIDE;
      csr_wdata = s[3:0];
      @(negedge clock);
      csr_wen   = 1'b0;
      cur_k = k;
      cur_s = s;
   endtask

   // one frame: a few random writes, fill what the run needs, then fire
   task automatic run_frame();
      int  n;
      int  r;
      int  c;
      bit  valid_shape;
      valid_shape = ((8 - cur_k) % cur_s) == 0;
      n = $urandom_range(2);
      repeat (n) send_write(FUNC_KERNEL, $urandom_range(7), $urandom_range(7),
                            pick_value());
      n = $urandom_range(1, 3);
      repeat (n) begin
         r = $urandom_range(7);
         c = $urandom_range(6);
         send_write(FUNC_IMAGE, r, c, pick_value());
      end
      if (valid_shape) begin
         for (int z = 0; z < cur_k; z++)
            for (int x = 0; x < cur_k; x++)
               if (!ker_written[z*8+x]) send_write(FUNC_KERNEL, z, x, pick_value());
         for (int p = 0; p < 63; p++)
            if (!img_written[p]) send_write(FUNC_IMAGE, p / 8, p % 8, pick_value());
      end
      send_write(FUNC_IMAGE, 7, 7, pick_value());
      wait_quiet();
   endtask

   initial begin
      int k;
      int s;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extreme coefficients, then two shapes with a bad stride
      send_write(FUNC_KERNEL, 0, 0, 16'h7fff);
      send_write(FUNC_KERNEL, 0, 7, 16'h8000);
      send_write(FUNC_KERNEL, 7, 0, 16'h0000);
      send_write(FUNC_KERNEL, 7, 7, 16'hffff);
      send_write(FUNC_IMAGE, 3, 5, 16'h8000);
      wait_quiet();
      set_shape(3, 2);      // size difference not a multiple of stride
      send_write(FUNC_IMAGE, 7, 7, 16'h8000);
      wait_quiet();
      set_shape(6, 4);
      send_write(FUNC_IMAGE, 7, 7, 16'h7fff);
      wait_quiet();

      // random frames across three idling phases
      for (int f = 0; f < 9; f++) begin
         if (f == 3) begin
            snd_idle = 69;
            rcv_idle = 24;
         end else if (f == 6) begin
            snd_idle = 0;
            rcv_idle = 0;
         end
         if (f == 0) begin
            k = 1; s = 1;     // largest output
         end else if (f == 1) begin
            k = 8; s = 8;     // kernel covers the whole image
         end else if ($urandom_range(4) == 0) begin
            do begin
               k = $urandom_range(1, 8);
               s = $urandom_range(1, 8);
            end while (((8 - k) % s) == 0);
         end else begin
            k = $urandom_range(1, 8);
            do s = $urandom_range(1, 8); while (((8 - k) % s) != 0);
         end
         set_shape(k, s);
         run_frame();
      end

      wait_quiet();
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
